// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk with reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition holds on every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
	`ASSERT_CLK(lbl, (1'b1 |-> (cond)), msg)

`endif

// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Types, widths and codes for the sorted-array priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

	localparam int DEPTH = 16;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Request codes; any other code acts as a peek
	localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

	// Per-cell control, driven from the top level
	typedef struct packed {
		logic                    push;     // insert value this cycle
		logic                    pop;      // shift toward the head this cycle
		logic                    occupied; // cell index below the count
		logic                    at_end;   // cell index equals the count
		logic signed [VAL_W-1:0] value;    // value being pushed
	} cell_ctl_t;

endpackage

`default_nettype wire

// File: src/sorted_array_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Descending sorted queue of signed values built as a chain of cells.
// ----------------------------------------------------------------------------
// Result: an item accepted at one edge shows its result, with done high, in
//   the cycle after that edge.
// Throughput: one item per cycle; every cell compares and shifts in parallel
//   in the same cycle, so busy stays low.
// Reset: count cleared, capacity limit set to DEPTH, no result pending;
//   cell contents are left as they are and never read until written.
`default_nettype none

module sorted_array_priority_queue (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// configuration
	input  wire                                    cfg_we,
	input  wire [spq_pkg::CAP_W-1:0]               cfg_wdata,
	// command
	input  wire                                    start,
	output logic                                   busy,
	input  wire [spq_pkg::FUNC_W-1:0]              func,
	input  wire signed [spq_pkg::VAL_W-1:0]        push_value,
	// result
	output logic                                   done,
	output logic [spq_pkg::STAT_W-1:0]             status,
	output logic signed [spq_pkg::VAL_W-1:0]       head_value,
	output logic signed [spq_pkg::VAL_W-1:0]       tail_value,
	output logic [spq_pkg::CNT_W-1:0]              entry_count,
	output logic                                   is_empty,
	output logic                                   is_full
);

	localparam int DEPTH = spq_pkg::DEPTH;
	localparam int CNT_W = spq_pkg::CNT_W;
	localparam int IDX_W = spq_pkg::IDX_W;
	localparam int CMP_W = spq_pkg::CMP_W;

	logic [spq_pkg::CAP_W-1:0]  cap_q;
	logic [CNT_W-1:0]           count_q;
	logic                       done_q;
	logic [spq_pkg::STAT_W-1:0] status_q;

	logic                       accept;
	logic                       full_now;
	logic                       empty_now;
	logic                       do_push;
	logic                       do_pop;
	logic [CMP_W-1:0]           cap_eff;
	logic [spq_pkg::STAT_W-1:0] status_d;
	logic [IDX_W-1:0]           tail_idx;

	logic signed [spq_pkg::VAL_W-1:0] cell_value [DEPTH];
	logic                             cell_le    [DEPTH];

	// The whole chain updates together, so a new command is always taken
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Capacity saturates at the number of cells
	assign cap_eff = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);

	assign full_now  = CMP_W'(count_q) >= cap_eff;
	assign empty_now = (count_q == '0);

	// Decode the request; a rejected push or pop leaves the chain alone
	always_comb begin
		do_push  = 1'b0;
		do_pop   = 1'b0;
		status_d = spq_pkg::ST_DONE;
		priority if (func == spq_pkg::FUNC_PUSH) begin
			if (full_now) begin
				status_d = spq_pkg::ST_FULL;
			end else begin
				do_push = accept;
			end
		end else if (func == spq_pkg::FUNC_POP) begin
			if (empty_now) begin
				status_d = spq_pkg::ST_EMPTY;
			end else begin
				do_pop = accept;
			end
		end else begin
			// peek, or the unused code: report only
			status_d = spq_pkg::ST_DONE;
		end
	end

	// Cell chain: each cell sees its left and right neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_pkg::cell_ctl_t               ctl;
		logic                             left_le;
		logic signed [spq_pkg::VAL_W-1:0] left_value;
		logic signed [spq_pkg::VAL_W-1:0] right_value;

		assign ctl.push     = do_push;
		assign ctl.pop      = do_pop;
		assign ctl.occupied = CNT_W'(i) < count_q;
		assign ctl.at_end   = CNT_W'(i) == count_q;
		assign ctl.value    = push_value;

		if (i == 0) begin : g_head
			assign left_le    = 1'b0;
			assign left_value = '0;
		end else begin : g_inner
			assign left_le    = cell_le[i-1];
			assign left_value = cell_value[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_value = cell_value[i];
		end else begin : g_notlast
			assign right_value = cell_value[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.left_le     (left_le),
			.left_value  (left_value),
			.right_value (right_value),
			.le          (cell_le[i]),
			.value       (cell_value[i])
		);
	end

	// Count, capacity and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= spq_pkg::CAP_RESET;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (do_push) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop) begin
				count_q <= count_q - CNT_W'(1);
			end
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
		end
	end

	// Result fields come straight from the updated chain during the done cycle
	assign tail_idx    = IDX_W'(count_q - CNT_W'(1));
	assign done        = done_q;
	assign status      = status_q;
	assign entry_count = count_q;
	assign is_empty    = empty_now;
	assign is_full     = full_now;
	assign head_value  = empty_now ? '0 : cell_value[0];
	assign tail_value  = empty_now ? '0 : cell_value[tail_idx];

endmodule

`default_nettype wire

// File: src/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: hold, take the left or right neighbor, or
// take the pushed value.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
	input  wire                                    clk,
	input  spq_pkg::cell_ctl_t                     ctl,
	input  wire                                    left_le,
	input  wire signed [spq_pkg::VAL_W-1:0]        left_value,
	input  wire signed [spq_pkg::VAL_W-1:0]        right_value,
	output logic                                   le,
	output logic signed [spq_pkg::VAL_W-1:0]       value
);

	logic signed [spq_pkg::VAL_W-1:0] value_q;
	logic signed [spq_pkg::VAL_W-1:0] value_d;

	// Held entry that is at or below the pushed value: the insert point is here or left
	assign le    = ctl.occupied && (value_q <= ctl.value);
	assign value = value_q;

	always_comb begin
		value_d = value_q;
		priority if (ctl.push) begin
			priority if (left_le) begin
				value_d = left_value;
			end else if (le || ctl.at_end) begin
				value_d = ctl.value;
			end else begin
				value_d = value_q;
			end
		end else if (ctl.pop) begin
			value_d = right_value;
		end else begin
			value_d = value_q;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

endmodule

`default_nettype wire

// File: src/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_port_checks
// Port-level checks on the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module spq_port_checks (
	input wire                                    clk,
	input wire                                    arst_n,
	input wire                                    start,
	input wire                                    busy,
	input wire                                    done,
	input wire [spq_pkg::STAT_W-1:0]              status,
	input wire signed [spq_pkg::VAL_W-1:0]        head_value,
	input wire signed [spq_pkg::VAL_W-1:0]        tail_value,
	input wire [spq_pkg::CNT_W-1:0]               entry_count,
	input wire                                    is_empty,
	input wire                                    is_full
);

	// Every accepted item yields exactly one result in the next cycle
	`ASSERT_CLK(a_result_follows, (start && !busy |=> done), "accepted item gave no result")
	`ASSERT_CLK(a_no_stray_result, (done |-> $past(start && !busy)), "result with no item")
	// Empty flag agrees with the count, and an empty queue shows zero values
	`ASSERT_CLK(a_empty_flag, (done |-> (is_empty == (entry_count == '0))), "empty flag wrong")
	`ASSERT_CLK(a_empty_zero, (done && is_empty |-> (head_value == '0) && (tail_value == '0)),
		"empty queue shows nonzero value")
	// A push refused for lack of room leaves the queue full
	`ASSERT_CLK(a_full_reject, (done && (status == spq_pkg::ST_FULL) |-> is_full),
		"push rejected but queue not full")

endmodule

bind sorted_array_priority_queue spq_port_checks u_spq_port_checks (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.status      (status),
	.head_value  (head_value),
	.tail_value  (tail_value),
	.entry_count (entry_count),
	.is_empty    (is_empty),
	.is_full     (is_full)
);

`default_nettype wire

// File: tb/sv/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Watches the command, result and configuration ports of the priority queue,
// keeps its own sorted copy of the held values and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module spq_checker (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire [spq_pkg::CAP_W-1:0]               cfg_wdata,
	input  wire                                    start,
	input  wire                                    busy,
	input  wire [spq_pkg::FUNC_W-1:0]              func,
	input  wire signed [spq_pkg::VAL_W-1:0]        push_value,
	input  wire                                    done,
	input  wire [spq_pkg::STAT_W-1:0]              status,
	input  wire signed [spq_pkg::VAL_W-1:0]        head_value,
	input  wire signed [spq_pkg::VAL_W-1:0]        tail_value,
	input  wire [spq_pkg::CNT_W-1:0]               entry_count,
	input  wire                                    is_empty,
	input  wire                                    is_full,
	output int                                     fail_count,
	output int                                     results_seen
);

	import spq_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] head;
		logic signed [VAL_W-1:0] tail;
		logic [CNT_W-1:0]        count;
		logic                    empty;
		logic                    full;
	} queue_view_t;

	queue_view_t             pending_views[$];
	logic signed [VAL_W-1:0] sorted_vals[DEPTH];
	int                      held;
	logic [CAP_W-1:0]        capacity;
	int                      mismatches;

	assign fail_count = mismatches;

	// Apply one request to the local copy and return the view after it
	function automatic queue_view_t apply_request(logic [FUNC_W-1:0] f,
			logic signed [VAL_W-1:0] v);
		queue_view_t o;
		int          cap;
		int          pos;
		int          i;
		cap = (capacity > DEPTH) ? DEPTH : int'(capacity);
		o.status = ST_DONE;
		if (f == FUNC_PUSH) begin
			if (held >= cap) begin
				o.status = ST_FULL;
			end else begin
				// land ahead of the first value not greater than the new one
				pos = held;
				for (i = 0; i < held; i++) begin
					if (sorted_vals[i] <= v) begin
						pos = i;
						break;
					end
				end
				for (i = held; i > pos; i--)
					sorted_vals[i] = sorted_vals[i-1];
				sorted_vals[pos] = v;
				held++;
			end
		end else if (f == FUNC_POP) begin
			if (held == 0) begin
				o.status = ST_EMPTY;
			end else begin
				for (i = 0; i + 1 < held; i++)
					sorted_vals[i] = sorted_vals[i+1];
				held--;
			end
		end
		o.head  = (held == 0) ? '0 : sorted_vals[0];
		o.tail  = (held == 0) ? '0 : sorted_vals[held-1];
		o.count = CNT_W'(held);
		o.empty = (held == 0);
		o.full  = (held >= cap);
		return o;
	endfunction

	task automatic note_field(string fname, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got,
			inout bit bad);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, fname, want, got);
			bad = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		queue_view_t want;
		bit          bad;
		if (!arst_n) begin
			capacity = CAP_RESET;
			held = 0;
			pending_views.delete();
			mismatches = 0;
			results_seen <= 0;
		end else begin
			// check the result first: it belongs to an item of an earlier edge
			if (done) begin
				results_seen <= results_seen + 1;
				if (pending_views.size() == 0) begin
					$display("%0t: result with nothing expected, actual status %0d count %0d",
						$time, status, entry_count);
					mismatches++;
				end else begin
					want = pending_views.pop_front();
					bad = 1'b0;
					note_field("status", VAL_W'(want.status), VAL_W'(status), bad);
					note_field("head_value", want.head, head_value, bad);
					note_field("tail_value", want.tail, tail_value, bad);
					note_field("entry_count", VAL_W'(want.count), VAL_W'(entry_count), bad);
					note_field("is_empty", VAL_W'(want.empty), VAL_W'(is_empty), bad);
					note_field("is_full", VAL_W'(want.full), VAL_W'(is_full), bad);
					if (bad)
						mismatches++;
				end
			end
			if (start && !busy)
				pending_views.push_back(apply_request(func, push_value));
			// the register takes its new value at this edge
			if (cfg_we)
				capacity = cfg_wdata;
		end
	end

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the sorted-array priority queue: a directed opening over the
// value extremes, empty and full corner cases and every request code, then
// random phases under several capacity settings with random idle bursts.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	import spq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 125;
	localparam int N_PHASES = 8;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CAP_W-1:0]        cfg_wdata = '0;
	logic                    start = 1'b0;
	logic [FUNC_W-1:0]       func = FUNC_PEEK;
	logic signed [VAL_W-1:0] push_value = '0;

	wire                     busy;
	wire                     done;
	wire [STAT_W-1:0]        status;
	wire signed [VAL_W-1:0]  head_value;
	wire signed [VAL_W-1:0]  tail_value;
	wire [CNT_W-1:0]         entry_count;
	wire                     is_empty;
	wire                     is_full;

	int                      fail_count;
	int                      results_seen;
	int                      items_sent = 0;
	int                      cycles = 0;
	bit                      gaps_on = 1'b1;

	sorted_array_priority_queue i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.push_value (push_value),
		.done       (done),
		.status     (status),
		.head_value (head_value),
		.tail_value (tail_value),
		.entry_count(entry_count),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

	spq_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.push_value  (push_value),
		.done        (done),
		.status      (status),
		.head_value  (head_value),
		.tail_value  (tail_value),
		.entry_count (entry_count),
		.is_empty    (is_empty),
		.is_full     (is_full),
		.fail_count  (fail_count),
		.results_seen(results_seen)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: end the run if the block stops answering
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Offer one item and hold it until the block takes it. Start stays high
	// afterwards, so back-to-back items go out without a dead cycle.
	task automatic send_item(logic [FUNC_W-1:0] f, logic signed [VAL_W-1:0] v);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		start      <= 1'b1;
		func       <= f;
		push_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		items_sent++;
	endtask

	// Drop start and wait until every result is back, plus a short margin.
	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (results_seen != items_sent)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Call only while drained
	task automatic write_capacity(logic [CAP_W-1:0] cap);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Mix small values (many duplicates), extremes and full-range words
	function automatic logic signed [VAL_W-1:0] pick_value;
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return VAL_W'($signed($urandom_range(0, 16)) - 8);
		else if (r < 45)
			return 32'sh7fff_ffff;
		else if (r < 50)
			return 32'sh8000_0000;
		else
			return $urandom;
	endfunction

	task automatic random_item(int push_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < push_pct)
			send_item(FUNC_PUSH, pick_value());
		else if (r < 88)
			send_item(FUNC_POP, $urandom);
		else if (r < 95)
			send_item(FUNC_PEEK, $urandom);
		else
			send_item(2'd3, $urandom);    // unused code, acts as a peek
	endtask

	initial begin
		logic [CAP_W-1:0] phase_caps[N_PHASES];
		phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd8, 5'd16};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue at reset capacity: peek, pop underflow, unused code
		send_item(FUNC_PEEK, '0);
		send_item(FUNC_POP, 32'shffff_ffff);
		send_item(2'd3, '0);
		// Extremes, duplicates and alternating bit patterns
		send_item(FUNC_PUSH, 32'sd0);
		send_item(FUNC_PUSH, 32'sh7fff_ffff);
		send_item(FUNC_PUSH, 32'sh8000_0000);
		send_item(FUNC_PUSH, -32'sd1);
		send_item(FUNC_PUSH, 32'sd0);
		send_item(FUNC_PUSH, 32'sh5555_5555);
		send_item(FUNC_PUSH, 32'shaaaa_aaaa);
		send_item(FUNC_PUSH, 32'sh7fff_ffff);
		send_item(FUNC_PEEK, 32'shffff_ffff);
		send_item(FUNC_POP, '0);
		send_item(2'd3, 32'shffff_ffff);
		drain();

		// Capacity dropped below the count: a push bounces, then pops shrink the count
		write_capacity(5'd2);
		send_item(FUNC_PUSH, 32'sd7);
		send_item(FUNC_PEEK, '0);
		send_item(FUNC_POP, '0);
		send_item(FUNC_POP, '0);
		send_item(FUNC_POP, '0);
		send_item(FUNC_POP, '0);
		drain();

		// Zero capacity: every push rejected, full reads high
		write_capacity(5'd0);
		send_item(FUNC_PUSH, 32'sd1);
		send_item(FUNC_PEEK, '0);
		send_item(FUNC_POP, '0);
		send_item(FUNC_POP, '0);
		send_item(FUNC_POP, '0);
		drain();

		// Random phases, each under its own capacity; the last one without gaps
		for (int p = 0; p < N_PHASES; p++) begin
			int push_pct;
			if (p == N_PHASES - 1) begin
				gaps_on = 1'b0;
				phase_caps[p] = CAP_W'($urandom_range(0, 31));
			end
			write_capacity(phase_caps[p]);
			push_pct = (phase_caps[p] >= 5'd16) ? 70 : $urandom_range(35, 65);
			for (int k = 0; k < PHASE_ITEMS; k++)
				random_item(push_pct);
			drain();
		end

		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
